// ===== rtl/core/cel_pkg.sv =====
// ----------------------------------------------------------------------------
// cel_pkg
// Shared types, operation codes and a helper function for the circular event log.
// ----------------------------------------------------------------------------
package cel_pkg;

   localparam int unsigned DefaultLogDepth = 32;
   localparam int unsigned AgeWidth        = 6;

   typedef enum logic [1:0] {
      OP_RECORD   = 2'd0,
      OP_SNAPSHOT = 2'd1,
      OP_CLEAR    = 2'd2
   } op_type;

   typedef struct packed {
      logic [1:0]         op;
      logic [7:0]         event_kind;
      logic signed [15:0] battery_in;
      logic               external_power;
      logic [31:0]        timestamp;
      logic [7:0]         reset_cause;
      logic [15:0]        max_entries;
   } req_type;

   typedef struct packed {
      logic                has_entry;
      logic [AgeWidth-1:0] entry_age;
      logic [7:0]          kind_out;
      logic signed [7:0]   battery_out;
      logic                power_out;
      logic [31:0]         time_out;
      logic [7:0]          reason_out;
      logic [31:0]         total_writes;
      logic                last;
   } rsp_type;

   typedef struct packed {
      logic [31:0]       time_val;
      logic [7:0]        kind;
      logic signed [7:0] battery;
      logic              power;
      logic [7:0]        reason;
   } entry_type;

   // Negative readings become -1, readings above 100 saturate at 100.
   function automatic logic signed [7:0] clamp_battery(input logic signed [15:0] raw);
      logic signed [7:0] result;
      if (raw[15]) begin
         result = -8'sd1;
      end else if (raw > 16'sd100) begin
         result = 8'sd100;
      end else begin
         result = signed'(raw[7:0]);
      end
      return result;
   endfunction

endpackage

// ===== rtl/core/cel_ring.sv =====
// ----------------------------------------------------------------------------
// cel_ring
// Event record store: one write port and one read port with registered data.
// ----------------------------------------------------------------------------
module cel_ring
   import cel_pkg::*;
#(
   parameter int unsigned DEPTH = DefaultLogDepth,
   parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  entry_type     wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output entry_type     rd_data
);

   entry_type mem_ff [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/circular_event_log.sv =====
// ----------------------------------------------------------------------------
// circular_event_log
// Ring of power event records with a 32-bit write counter and newest-first
// snapshot readout.
//
//   Channel   Direction  Signals                          Payload
//   req       in         req_valid, req_ready, req_data   req_type
//   rsp       out        rsp_valid, rsp_ready, rsp_data   rsp_type
//
// Records and clears are handled in S_IDLE. A snapshot reads the newest entry
// in S_IDLE and hands out results from S_LOAD: the store has one read port, so
// one entry is read per cycle, and a stalled result holds the run. Reset clears
// the counter, write pointer, state and output valid only; the store needs no
// clearing pass, as only written entries are ever read.
// ----------------------------------------------------------------------------
module circular_event_log
   import cel_pkg::*;
#(
   parameter int unsigned LOG_DEPTH = DefaultLogDepth
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int unsigned AW = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
   localparam int unsigned CW = $clog2(LOG_DEPTH + 1);

   typedef enum logic {
      S_IDLE,
      S_LOAD
   } state_type;

   state_type       state_ff, state_in;
   logic [31:0]     write_count_ff, write_count_in;
   logic [AW-1:0]   wptr_ff, wptr_in;
   logic [AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   remain_ff, remain_in;
   logic [AgeWidth-1:0] age_ff, age_in;
   logic            empty_ff, empty_in;
   logic [31:0]     total_ff, total_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_type         rsp_data_ff, rsp_data_in;

   logic            wr_en;
   logic            rd_en;
   logic [AW-1:0]   rd_addr;
   entry_type       wr_data;
   entry_type       rd_data;
   logic [CW-1:0]   held;
   logic [CW-1:0]   run_len;
   logic            rsp_free;

   cel_ring #(
      .DEPTH (LOG_DEPTH),
      .AW    (AW)
   ) u_ring (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wptr_ff),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   assign wr_data.time_val = req_data.timestamp;
   assign wr_data.kind     = req_data.event_kind;
   assign wr_data.battery  = clamp_battery(req_data.battery_in);
   assign wr_data.power    = req_data.external_power;
   assign wr_data.reason   = req_data.reset_cause;

   assign held    = (write_count_ff < 32'(LOG_DEPTH)) ? CW'(write_count_ff) : CW'(LOG_DEPTH);
   assign run_len = (16'(held) < req_data.max_entries) ? held : CW'(req_data.max_entries);

   always_comb begin
      state_in       = state_ff;
      write_count_in = write_count_ff;
      wptr_in        = wptr_ff;
      rd_ptr_in      = rd_ptr_ff;
      remain_in      = remain_ff;
      age_in         = age_ff;
      empty_in       = empty_ff;
      total_in       = total_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_data_in    = rsp_data_ff;
      wr_en          = 1'b0;
      rd_en          = 1'b0;
      rd_addr        = rd_ptr_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               case (req_data.op)
                  OP_RECORD: begin
                     wr_en = 1'b1;
                     if (write_count_ff == '1) begin
                        write_count_in = '0;
                        wptr_in        = '0;
                     end else begin
                        write_count_in = write_count_ff + 32'd1;
                        wptr_in = (wptr_ff == AW'(LOG_DEPTH - 1)) ? '0 : wptr_ff + AW'(1);
                     end
                  end
                  OP_SNAPSHOT: begin
                     total_in  = write_count_ff;
                     age_in    = '0;
                     remain_in = run_len;
                     empty_in  = (run_len == '0);
                     rd_addr   = (wptr_ff == '0) ? AW'(LOG_DEPTH - 1) : wptr_ff - AW'(1);
                     rd_en     = (run_len != '0);
                     rd_ptr_in = rd_addr;
                     state_in  = S_LOAD;
                  end
                  OP_CLEAR: begin
                     write_count_in = '0;
                     wptr_in        = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_LOAD: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in.total_writes = total_ff;
               if (empty_ff) begin
                  rsp_data_in.has_entry   = 1'b0;
                  rsp_data_in.entry_age   = '0;
                  rsp_data_in.kind_out    = '0;
                  rsp_data_in.battery_out = '0;
                  rsp_data_in.power_out   = 1'b0;
                  rsp_data_in.time_out    = '0;
                  rsp_data_in.reason_out  = '0;
                  rsp_data_in.last        = 1'b1;
                  state_in                = S_IDLE;
               end else begin
                  rsp_data_in.has_entry   = 1'b1;
                  rsp_data_in.entry_age   = age_ff;
                  rsp_data_in.kind_out    = rd_data.kind;
                  rsp_data_in.battery_out = rd_data.battery;
                  rsp_data_in.power_out   = rd_data.power;
                  rsp_data_in.time_out    = rd_data.time_val;
                  rsp_data_in.reason_out  = rd_data.reason;
                  rsp_data_in.last        = (remain_ff == CW'(1));
                  if (remain_ff == CW'(1)) begin
                     state_in = S_IDLE;
                  end else begin
                     remain_in = remain_ff - CW'(1);
                     age_in    = age_ff + AgeWidth'(1);
                     rd_addr   = (rd_ptr_ff == '0) ? AW'(LOG_DEPTH - 1) : rd_ptr_ff - AW'(1);
                     rd_en     = 1'b1;
                     rd_ptr_in = rd_addr;
                  end
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         write_count_ff <= '0;
         wptr_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         write_count_ff <= write_count_in;
         wptr_ff        <= wptr_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      rd_ptr_ff   <= rd_ptr_in;
      remain_ff   <= remain_in;
      age_ff      <= age_in;
      empty_ff    <= empty_in;
      total_ff    <= total_in;
      rsp_data_ff <= rsp_data_in;
   end

`ifndef SYNTHESIS
   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.has_entry) |-> rsp_data.last)
      else $error("empty snapshot result without last");

   a_count_frozen_in_run: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LOAD) |=> $stable(write_count_ff))
      else $error("write counter changed during a snapshot run");

   a_total_matches_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LOAD) |-> (total_ff == write_count_ff))
      else $error("snapshot total does not match the write counter");

   a_remain_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LOAD && !empty_ff) |-> (remain_ff != '0))
      else $error("snapshot run with no entries left");
`endif

endmodule
